FILE: hdl/lorentz_boost_matrix_core_defines.svh
// ---------------------------------------------------------------------------
// Lorentz boost matrix core: assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef LORENTZ_BOOST_MATRIX_CORE_DEFINES_SVH
`define LORENTZ_BOOST_MATRIX_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBM_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lorentz boost matrix core: property failed");

// Next-cycle implication, disabled during reset.
`define LBM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lorentz boost matrix core: property failed");

`endif

FILE: hdl/lbm_pkg.sv
// ---------------------------------------------------------------------------
// Lorentz boost matrix package
// Fixed-point formats, pipeline stage map and the stage payload type.
// ---------------------------------------------------------------------------
package lbm_pkg;

  localparam int unsigned FB_IN  = 15;
  localparam int unsigned FB_OUT = 16;

  // Square of unit speed and the shift of the gamma-squared numerator.
  localparam int unsigned ONE2_SHIFT = 2 * FB_IN;
  localparam int unsigned NUM_SHIFT  = 2 * FB_IN + 2 * FB_OUT;

  localparam int unsigned DIV_STAGES  = NUM_SHIFT + 1;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned KDIV_STAGES = 32;

  localparam int unsigned S_SUM   = 1;
  localparam int unsigned S_DIV0  = S_SUM + 1;
  localparam int unsigned S_SQRT0 = S_DIV0 + DIV_STAGES;
  localparam int unsigned S_GSQ   = S_SQRT0 + SQRT_STAGES;
  localparam int unsigned S_KDIV0 = S_GSQ + 1;
  localparam int unsigned S_MUL   = S_KDIV0 + KDIV_STAGES;
  localparam int unsigned S_OUT   = S_MUL + 1;
  localparam int unsigned N_STAGES = S_OUT + 1;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 320;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic [2:0][30:0] sqv;
    logic [2:0][30:0] crs;
    logic             inv;
    logic [30:0]      d;
    logic [30:0]      rd;
    logic [63:0]      qv;
    logic [34:0]      sr;
    logic [31:0]      root;
    logic [63:0]      gsq;
    logic [31:0]      rk;
    logic [31:0]      kq;
    logic [2:0][47:0] tm;
    logic [2:0][61:0] sp;
    logic [2:0][61:0] cp;
    logic [30:0]      gam;
    logic [8:0][31:0] res;
  } stage_t;

endpackage

FILE: hdl/lorentz_boost_matrix_core.sv
// Throughput: one vector per cycle while the result side is not stalled; every stage is a register stage.
// The divider, square root and k divider resolve one bit per stage.
// A stall on the result side holds the whole pipeline in place.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// ---------------------------------------------------------------------------
// Lorentz boost matrix core
// Pipelined gamma, k and the ten distinct boost matrix entries per vector.
// ---------------------------------------------------------------------------
module lorentz_boost_matrix_core
  import lbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // beta_x[15:0], beta_y[31:16], beta_z[47:32]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // lorentz_factor[30:0], time_x, time_y, time_z, space_xx, space_yy,
  // space_zz, space_xy, space_xz, space_yz (32 bits each from bit 31), zero pad
  output logic [OUT_W-1:0] out_tdata,
  // invalid[0]
  output logic             out_tuser
);

  stage_t pipe_r   [N_STAGES];
  stage_t pipe_nxt [N_STAGES];
  logic [N_STAGES-1:0] vld_r, vld_nxt;
  logic enable;

  function automatic logic [31:0] clamp32(logic [63:0] m, logic neg);
    logic [63:0] lim;
    logic [63:0] mg;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    mg  = (m > lim) ? lim : m;
    return neg ? (32'd0 - mg[31:0]) : mg[31:0];
  endfunction

  function automatic stage_t stage_fn(stage_t x, int unsigned s);
    stage_t y;
    logic [32:0] sum;
    logic [31:0] rem2;
    logic        qb;
    logic [36:0] srem2;
    logic [36:0] trial;
    logic [34:0] srb;
    logic [31:0] rtb;
    logic [31:0] dk;
    logic [31:0] rkb;
    logic [31:0] kqb;
    logic [32:0] krem2;
    logic [63:0] t;
    y = x;
    if (s == S_SUM) begin
      sum   = {2'b0, x.sqv[0]} + {2'b0, x.sqv[1]} + {2'b0, x.sqv[2]};
      y.inv = (sum >= (33'd1 << ONE2_SHIFT));
      y.d   = y.inv ? 31'd1 : 31'((33'd1 << ONE2_SHIFT) - sum);
      y.rd  = '0;
      y.qv  = '0;
    end else if (s >= S_DIV0 && s < S_SQRT0) begin
      // Long division of one shifted to the top numerator bit by d.
      rem2 = {x.rd, (s == S_DIV0)};
      qb   = (rem2 >= {1'b0, x.d});
      y.rd = qb ? 31'(rem2 - {1'b0, x.d}) : rem2[30:0];
      y.qv = {x.qv[62:0], qb};
    end else if (s >= S_SQRT0 && s < S_GSQ) begin
      srb   = (s == S_SQRT0) ? '0 : x.sr;
      rtb   = (s == S_SQRT0) ? '0 : x.root;
      srem2 = {srb, x.qv[63:62]};
      trial = {3'b0, rtb, 2'b01};
      if (srem2 >= trial) begin
        y.sr   = 35'(srem2 - trial);
        y.root = {rtb[30:0], 1'b1};
      end else begin
        y.sr   = srem2[34:0];
        y.root = {rtb[30:0], 1'b0};
      end
      y.qv = {x.qv[61:0], 2'b00};
    end else if (s == S_GSQ) begin
      y.gsq = x.root * x.root;
    end else if (s >= S_KDIV0 && s < S_MUL) begin
      // The quotient fits 32 bits, so the upper half seeds the remainder.
      dk    = x.root + (32'd1 << FB_OUT);
      rkb   = (s == S_KDIV0) ? x.gsq[63:32] : x.rk;
      kqb   = (s == S_KDIV0) ? '0 : x.kq;
      krem2 = {rkb, x.gsq[31]};
      qb    = (krem2 >= {1'b0, dk});
      y.rk  = qb ? 32'(krem2 - {1'b0, dk}) : krem2[31:0];
      y.kq  = {kqb[30:0], qb};
      y.gsq = {x.gsq[62:0], 1'b0};
    end else if (s == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        y.tm[i] = x.root * x.mag[i];
        y.sp[i] = x.kq * x.sqv[i][29:0];
        y.cp[i] = x.kq * x.crs[i][29:0];
      end
    end else if (s == S_OUT) begin
      y.gam = (x.root > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : x.root[30:0];
      for (int i = 0; i < 3; i++) begin
        t = 64'(x.tm[i] >> FB_IN);
        y.res[i] = clamp32(t, x.neg[i] && (x.mag[i] != 16'd0));
        t = 64'(x.sp[i] >> ONE2_SHIFT) + (64'd1 << FB_OUT);
        y.res[3 + i] = clamp32(t, 1'b0);
      end
      for (int n = 0; n < 3; n++) begin
        t = 64'(x.cp[n] >> ONE2_SHIFT);
        unique case (n)
          0: qb = x.neg[0] ^ x.neg[1];
          1: qb = x.neg[0] ^ x.neg[2];
          default: qb = x.neg[1] ^ x.neg[2];
        endcase
        y.res[6 + n] = clamp32(t, qb && (x.crs[n] != 31'd0));
      end
      if (x.inv) begin
        y.gam = '0;
        y.res = '0;
      end
    end
    return y;
  endfunction

  assign enable    = !(out_tvalid && !out_tready);
  assign in_tready = enable;

  // Entry stage: magnitudes, signs and the six component products.
  always_comb begin
    stage_t e;
    logic [15:0] raw;
    logic [31:0] p;
    e = '0;
    for (int i = 0; i < 3; i++) begin
      raw      = in_tdata[16*i +: 16];
      e.neg[i] = raw[15];
      e.mag[i] = raw[15] ? (16'd0 - raw) : raw;
    end
    for (int i = 0; i < 3; i++) begin
      p        = e.mag[i] * e.mag[i];
      e.sqv[i] = p[30:0];
    end
    p = e.mag[0] * e.mag[1];
    e.crs[0] = p[30:0];
    p = e.mag[0] * e.mag[2];
    e.crs[1] = p[30:0];
    p = e.mag[1] * e.mag[2];
    e.crs[2] = p[30:0];
    pipe_nxt[0] = e;
    vld_nxt[0]  = in_tvalid;
  end

  for (genvar g = 1; g < N_STAGES; g++) begin : g_stage
    always_comb begin
      pipe_nxt[g] = stage_fn(pipe_r[g-1], g);
      vld_nxt[g]  = vld_r[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (enable) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign out_tvalid = vld_r[N_STAGES-1];
  assign out_tuser  = pipe_r[N_STAGES-1].inv;
  assign out_tdata  = {1'b0,
                       pipe_r[N_STAGES-1].res[8], pipe_r[N_STAGES-1].res[7],
                       pipe_r[N_STAGES-1].res[6], pipe_r[N_STAGES-1].res[5],
                       pipe_r[N_STAGES-1].res[4], pipe_r[N_STAGES-1].res[3],
                       pipe_r[N_STAGES-1].res[2], pipe_r[N_STAGES-1].res[1],
                       pipe_r[N_STAGES-1].res[0], pipe_r[N_STAGES-1].gam};

endmodule

FILE: hdl/lbm_checker.sv
// ---------------------------------------------------------------------------
// Lorentz boost matrix port checker
// Watches the ports of the core over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "lorentz_boost_matrix_core_defines.svh"

module lbm_checker
  import lbm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  `LBM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `LBM_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  `LBM_ASSERT_NOW(a_ready_follows, out_tready, in_tready)
  `LBM_ASSERT_NOW(a_invalid_zero, out_tvalid && out_tuser, out_tdata == '0)
  `LBM_ASSERT_NOW(a_gamma_ge_one, out_tvalid && !out_tuser, (out_tdata[30:0] >= 31'h10000) && (out_tdata[158:127] >= 32'h10000))

endmodule

bind lorentz_boost_matrix_core lbm_checker u_lbm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

FILE: bench/lorentz_boost_matrix_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Lorentz boost matrix core testbench
// Streams velocity vectors through the core and compares every matrix entry
// and the invalid flag against an exact fixed-point boost calculation.
// ---------------------------------------------------------------------------
module lorentz_boost_matrix_core_tb
  import lbm_pkg::*;
();

  localparam int unsigned LATENCY = 131;
  localparam int unsigned N_RANDOM = 750;

  typedef struct packed {
    logic [15:0] bz;
    logic [15:0] by;
    logic [15:0] bx;
  } velocity_t;

  typedef struct {
    logic [30:0]      gamma;
    logic [8:0][31:0] entry;
    logic             invalid;
  } boost_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  velocity_t pending_vectors[$];
  boost_t    expected_boosts[$];
  int        fail_count;
  int        results_seen;
  int        invalid_seen;
  bit        quiet_tail;
  bit        rx_hold;
  int        tx_gap;
  int        rx_gap;

  string entry_names[9] = '{"time_x", "time_y", "time_z", "space_xx", "space_yy",
                            "space_zz", "space_xy", "space_xz", "space_yz"};

  lorentz_boost_matrix_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [31:0] saturate(logic [127:0] mag, bit neg);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    m = (mag > lim) ? lim : mag;
    return neg ? 32'(-m) : m[31:0];
  endfunction

  function automatic boost_t compute_boost(velocity_t v);
    boost_t r;
    logic [15:0] raw[3];
    logic [16:0] mag[3];
    bit neg[3];
    logic [63:0] sq, d, g, k;
    logic [127:0] q, t;
    logic [63:0] c;
    int pi[3] = '{0, 0, 1};
    int pj[3] = '{1, 2, 2};
    raw[0] = v.bx;
    raw[1] = v.by;
    raw[2] = v.bz;
    for (int i = 0; i < 3; i++) begin
      neg[i] = raw[i][15];
      mag[i] = neg[i] ? 17'h10000 - raw[i] : {1'b0, raw[i]};
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r.gamma = '0;
    r.entry = '0;
    r.invalid = 1'b1;
    if (sq >= (64'd1 << (2 * FB_IN))) return r;
    r.invalid = 1'b0;
    d = (64'd1 << (2 * FB_IN)) - sq;
    q = (128'd1 << (2 * FB_IN + 2 * FB_OUT)) / d;
    g = 0;
    for (int b = 63; b >= 0; b--) begin
      c = g | (64'd1 << b);
      if (128'(c) * 128'(c) <= q) g = c;
    end
    k = 64'((128'(g) * 128'(g)) / (128'(g) + (128'd1 << FB_OUT)));
    r.gamma = (g > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : g[30:0];
    for (int i = 0; i < 3; i++) begin
      t = (128'(g) * 128'(mag[i])) >> FB_IN;
      r.entry[i] = saturate(t, neg[i] && mag[i] != 0);
      t = ((128'(k) * 128'(mag[i]) * 128'(mag[i])) >> (2 * FB_IN)) + (128'd1 << FB_OUT);
      r.entry[3 + i] = saturate(t, 1'b0);
      t = (128'(k) * 128'(mag[pi[i]]) * 128'(mag[pj[i]])) >> (2 * FB_IN);
      r.entry[6 + i] = saturate(t, neg[pi[i]] != neg[pj[i]]
                                 && mag[pi[i]] != 0 && mag[pj[i]] != 0);
    end
    return r;
  endfunction

  // Sender: one transfer per accepted handshake, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      tx_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_boosts.push_back(compute_boost(velocity_t'(in_tdata)));
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_vectors.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_vectors.pop_front();
          if (!quiet_tail && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 19);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a forced long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap <= 0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin
    boost_t exp_b;
    logic [31:0] got;
    int errs;
    errs = 0;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_boosts.size() == 0) begin
        $error("unexpected result transfer");
        errs++;
      end else begin
        exp_b = expected_boosts.pop_front();
        if (exp_b.invalid) invalid_seen <= invalid_seen + 1;
        if (out_tdata[30:0] !== exp_b.gamma) begin
          $error("lorentz_factor: expected %h, got %h", exp_b.gamma, out_tdata[30:0]);
          errs++;
        end
        for (int i = 0; i < 9; i++) begin
          got = out_tdata[31 + 32 * i +: 32];
          if (got !== exp_b.entry[i]) begin
            $error("%s: expected %h, got %h", entry_names[i], exp_b.entry[i], got);
            errs++;
          end
        end
        if (out_tuser !== exp_b.invalid) begin
          $error("invalid: expected %b, got %b", exp_b.invalid, out_tuser);
          errs++;
        end
      end
      fail_count <= fail_count + errs;
    end
  end

  function automatic velocity_t vec(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [15:0] rand_component(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2047) - 1024);
      default: return 16'($urandom_range(0, 36000) - 18000);
    endcase
  endfunction

  initial begin
    velocity_t v;
    int m;
    rst_n = 1'b0;
    quiet_tail = 1'b0;
    rx_hold = 1'b0;
    fail_count = 0;
    results_seen = 0;
    invalid_seen = 0;
    // Directed: rest, extremes, light speed edge, near-light, signs.
    pending_vectors.push_back(vec(0, 0, 0));
    pending_vectors.push_back(vec(32767, 0, 0));
    pending_vectors.push_back(vec(0, -32767, 0));
    pending_vectors.push_back(vec(0, 0, 32767));
    pending_vectors.push_back(vec(-32768, 0, 0));
    pending_vectors.push_back(vec(0, -32768, 0));
    pending_vectors.push_back(vec(0, 0, -32768));
    pending_vectors.push_back(vec(-32768, -32768, -32768));
    pending_vectors.push_back(vec(32767, 32767, 32767));
    pending_vectors.push_back(vec(23170, 23170, 0));
    pending_vectors.push_back(vec(23170, -23170, 0));
    pending_vectors.push_back(vec(-18918, 18918, -18918));
    pending_vectors.push_back(vec(18918, -18918, 18919));
    pending_vectors.push_back(vec(-1, 1, -1));
    pending_vectors.push_back(vec(16384, -16384, 16384));
    pending_vectors.push_back(vec(-32767, 1, 0));
    pending_vectors.push_back(vec(1, -1, -32766));
    pending_vectors.push_back(vec(-21845, -21845, 21845));
    pending_vectors.push_back(vec(12345, -23456, 4321));
    for (int i = 0; i < N_RANDOM; i++) begin
      m = $urandom_range(0, 2);
      v.bx = rand_component(m);
      v.by = rand_component(m);
      v.bz = rand_component(m);
      pending_vectors.push_back(v);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Long receiver hold-off so the pipeline fills and stalls the input.
    repeat (40) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
    wait (pending_vectors.size() < 80);
    quiet_tail <= 1'b1;
    wait (pending_vectors.size() == 0 && !in_tvalid);
    wait (expected_boosts.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d boost matrices (%0d superluminal), with stalls and backpressure.",
             results_seen, invalid_seen);
    if (fail_count == 0 && expected_boosts.size() == 0) begin
      $display("[lorentz_boost_matrix_core] OK");
    end else begin
      $display("[lorentz_boost_matrix_core] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[lorentz_boost_matrix_core] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lbm_pkg.sv
hdl/lorentz_boost_matrix_core.sv
hdl/lbm_checker.sv
bench/lorentz_boost_matrix_core_tb.sv
